// File: rtl/ssb_pkg.sv
`timescale 1ns / 1ps

package ssb_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_CHECK,
    ST_DRAW
  } ssb_state_e;

  // Item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_DRAW  = 2'd1;
  localparam logic [1:0] KIND_SET   = 2'd2;
  localparam logic [1:0] KIND_CHECK = 2'd3;

  // Text image characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  // Text image layout: flag characters first, then the pixels
  localparam logic [6:0] FLAG_CHARS = 7'd8;
  localparam logic [6:0] IMAGE_END  = 7'd72;

  localparam int SPRITE_NUM_W = 12;

  // Reduced sprite number from the slot unit
  typedef struct packed {
    logic                    busy;
    logic [SPRITE_NUM_W-1:0] value;
  } slot_status_t;

endpackage

// File: rtl/ssb_slot_mod.sv
`timescale 1ns / 1ps

// Sprite number modulo SPRITE_COUNT: quotient by reciprocal multiplication registered at the
// taking edge, remainder registered in the cycle after.
module ssb_slot_mod #(
  parameter int SPRITE_COUNT = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [ssb_pkg::SPRITE_NUM_W-1:0]  sprite_i,
  output ssb_pkg::slot_status_t             status_o
);

  localparam int NumW   = ssb_pkg::SPRITE_NUM_W;
  localparam int ShiftW = 2 * NumW;
  localparam int ProdW  = 3 * NumW + 1;

  // 2^24 / count rounded up; exact quotient for any 12-bit sprite number
  localparam longint unsigned Recip =
    ((64'd1 << ShiftW) + longint'(SPRITE_COUNT) - 64'd1) / longint'(SPRITE_COUNT);
  localparam logic [ShiftW:0]  RecipL = (ShiftW + 1)'(Recip);
  localparam logic [NumW-1:0]  CountL = NumW'(SPRITE_COUNT);

  logic             busy_q;
  logic [NumW-1:0]  num_q;
  logic [NumW-1:0]  quot_q;
  logic [NumW-1:0]  rem_q;
  logic [ProdW-1:0] prod;
  logic [NumW-1:0]  quot;

  assign prod = ProdW'(sprite_i) * ProdW'(RecipL);
  assign quot = prod[ShiftW +: NumW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start_i;
    end
  end

  // product fits in 12 bits, so the truncated multiply is exact
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= sprite_i;
      quot_q <= quot;
    end
    if (busy_q) begin
      rem_q <= num_q - quot_q * CountL;
    end
  end

  assign status_o.busy  = busy_q;
  assign status_o.value = rem_q;

  a_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && $past(busy_q)) |-> (32'(rem_q) < SPRITE_COUNT))
    else $error("slot remainder not below sprite count");

  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("slot reduction did not start");

  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q)
    else $error("slot reduction took more than one cycle");

endmodule

// File: rtl/sprite_store_blitter.sv
`timescale 1ns / 1ps

// Order: a draw or check gives its first result after sprite number reduction, dispatch,
//   store read and result register; a load or set is read and written back after reduction
//   and dispatch (a load past the image writes nothing); then the next item can be taken.
// Throughput: one item at a time. A draw gives 64 results on consecutive cycles while the
//   output is not stalled, one read of the sprite row memory each; the next item is taken
//   once the last read is out.
// Reset: a clearing pass writes zero to every sprite row and flag byte; no item is taken
//   meanwhile. Transparency mask resets to 1.
module sprite_store_blitter #(
  parameter int SPRITE_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [11:0] sprite_i,
  input  logic [6:0]  position_i,
  input  logic [7:0]  text_char_i,
  input  logic [14:0] pos_x_i,
  input  logic [14:0] pos_y_i,
  input  logic        flip_h_i,
  input  logic        flip_v_i,
  input  logic [2:0]  flag_index_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] pixel_x_o,
  output logic [15:0] pixel_y_o,
  output logic [3:0]  color_o,
  output logic        write_enable_o,
  output logic        flag_value_o,
  output logic        last_o
);

  localparam int SlotW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
  localparam int RowW  = SlotW + 3;
  localparam int Rows  = SPRITE_COUNT * 8;

  // Hex digit decode; ok is low for anything outside 0-9 and a-f
  function automatic logic [4:0] hex_decode(logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= ssb_pkg::CH_ZERO && ch <= ssb_pkg::CH_NINE) begin
      r = {1'b1, 4'(ch - ssb_pkg::CH_ZERO)};
    end else if (ch >= ssb_pkg::CH_A && ch <= ssb_pkg::CH_F) begin
      r = {1'b1, 4'(ch - ssb_pkg::CH_A + ssb_pkg::HEX_TEN)};
    end
    return r;
  endfunction

  ssb_pkg::ssb_state_e   state_q, state_d;
  ssb_pkg::slot_status_t slot_st;

  logic [SlotW-1:0] slot;
  logic             accept;

  // Item registers
  logic [1:0]  kind_q;
  logic [6:0]  position_q;
  logic [7:0]  char_q;
  logic [14:0] pos_x_q;
  logic [14:0] pos_y_q;
  logic        flip_h_q;
  logic        flip_v_q;
  logic [2:0]  fidx_q;

  logic [RowW-1:0] clr_cnt_q;
  logic            clr_last;
  logic [5:0]      step_q;
  logic [15:0]     mask_q;

  // Outstanding read for the result path
  logic        rd_pending_q;
  logic        rq_check_q;
  logic        rq_last_q;
  logic [15:0] rq_x_q;
  logic [15:0] rq_y_q;
  logic [2:0]  rq_rx_q;
  logic [2:0]  rq_fidx_q;

  logic        consume;
  logic        issue;

  // Result register
  logic        out_valid_q;
  logic [15:0] pixel_x_q;
  logic [15:0] pixel_y_q;
  logic [3:0]  color_q;
  logic        we_q;
  logic        flag_q;
  logic        last_q;

  // Memories
  logic [31:0] pix_mem [Rows];
  logic [7:0]  flag_mem [SPRITE_COUNT];
  logic [31:0] pix_rdata_q;
  logic [7:0]  flag_rdata_q;

  logic            pix_we, pix_re, flag_we, flag_re;
  logic [RowW-1:0] pix_waddr, pix_raddr;
  logic [SlotW-1:0] flag_waddr;
  logic [31:0]     pix_wdata;
  logic [7:0]      flag_wdata;

  logic [6:0]  pix_pos;
  logic [2:0]  sx, sy, rx, ry;
  logic        is_flag_op, is_pix_load;
  logic [4:0]  hex;
  logic [2:0]  fbit_idx;
  logic        fbit_set;
  logic [31:0] row_new;
  logic [7:0]  flag_new;
  logic [3:0]  pix_color;

  ssb_slot_mod #(
    .SPRITE_COUNT(SPRITE_COUNT)
  ) u_slot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .sprite_i(sprite_i),
    .status_o(slot_st)
  );

  assign slot     = slot_st.value[SlotW-1:0];
  assign clr_last = clr_cnt_q == RowW'(Rows - 1);

  assign pix_pos     = position_q - ssb_pkg::FLAG_CHARS;
  assign sx          = step_q[2:0];
  assign sy          = step_q[5:3];
  assign rx          = flip_h_q ? ~sx : sx;
  assign ry          = flip_v_q ? ~sy : sy;
  assign is_flag_op  = (kind_q == ssb_pkg::KIND_SET) ||
                       (kind_q == ssb_pkg::KIND_LOAD && position_q < ssb_pkg::FLAG_CHARS);
  assign is_pix_load = kind_q == ssb_pkg::KIND_LOAD && position_q >= ssb_pkg::FLAG_CHARS &&
                       position_q < ssb_pkg::IMAGE_END;
  assign hex         = hex_decode(char_q);
  assign fbit_idx    = (kind_q == ssb_pkg::KIND_LOAD) ? position_q[2:0] : fidx_q;
  assign fbit_set    = (kind_q == ssb_pkg::KIND_SET) || (char_q == ssb_pkg::CH_ONE);
  assign pix_color   = pix_rdata_q[{rq_rx_q, 2'b00} +: 4];

  always_comb begin
    row_new = pix_rdata_q;
    row_new[{pix_pos[2:0], 2'b00} +: 4] = hex[3:0];
  end

  always_comb begin
    flag_new = flag_rdata_q;
    flag_new[fbit_idx] = fbit_set;
  end

  assign consume = rd_pending_q && (!out_valid_q || !out_stall_i);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ssb_pkg::ST_CLEAR: begin
        if (clr_last) state_d = ssb_pkg::ST_IDLE;
      end
      ssb_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ssb_pkg::ST_MOD;
      end
      ssb_pkg::ST_MOD: begin
        // the read data registers must be free before this item uses them
        if (!slot_st.busy && !rd_pending_q) begin
          case (kind_q)
            ssb_pkg::KIND_LOAD: begin
              state_d = (position_q < ssb_pkg::IMAGE_END) ? ssb_pkg::ST_RMW_RD
                                                          : ssb_pkg::ST_IDLE;
            end
            ssb_pkg::KIND_DRAW: state_d = ssb_pkg::ST_DRAW;
            ssb_pkg::KIND_SET:  state_d = ssb_pkg::ST_RMW_RD;
            default:            state_d = ssb_pkg::ST_CHECK;
          endcase
        end
      end
      ssb_pkg::ST_RMW_RD: state_d = ssb_pkg::ST_RMW_WR;
      ssb_pkg::ST_RMW_WR: state_d = ssb_pkg::ST_IDLE;
      ssb_pkg::ST_CHECK: begin
        if (issue) state_d = ssb_pkg::ST_IDLE;
      end
      ssb_pkg::ST_DRAW: begin
        if (issue && step_q == 6'd63) state_d = ssb_pkg::ST_IDLE;
      end
      default: state_d = ssb_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    in_stall_o = 1'b1;
    issue      = 1'b0;
    pix_we     = 1'b0;
    pix_re     = 1'b0;
    flag_we    = 1'b0;
    flag_re    = 1'b0;
    pix_waddr  = {slot, pix_pos[5:3]};
    pix_raddr  = {slot, pix_pos[5:3]};
    pix_wdata  = row_new;
    flag_waddr = slot;
    flag_wdata = flag_new;
    case (state_q)
      ssb_pkg::ST_CLEAR: begin
        pix_we     = 1'b1;
        flag_we    = 1'b1;
        pix_waddr  = clr_cnt_q;
        pix_wdata  = 32'd0;
        flag_waddr = clr_cnt_q[RowW-1:3];
        flag_wdata = 8'd0;
      end
      ssb_pkg::ST_IDLE: in_stall_o = 1'b0;
      ssb_pkg::ST_RMW_RD: begin
        pix_re  = is_pix_load;
        flag_re = is_flag_op;
      end
      ssb_pkg::ST_RMW_WR: begin
        pix_we  = is_pix_load && hex[4];
        flag_we = is_flag_op;
      end
      ssb_pkg::ST_CHECK: begin
        issue   = !rd_pending_q || consume;
        flag_re = issue;
      end
      ssb_pkg::ST_DRAW: begin
        issue     = !rd_pending_q || consume;
        pix_re    = issue;
        pix_raddr = {slot, ry};
      end
      default: ;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (pix_we) pix_mem[pix_waddr] <= pix_wdata;
    if (pix_re) pix_rdata_q <= pix_mem[pix_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (flag_we) flag_mem[flag_waddr] <= flag_wdata;
    if (flag_re) flag_rdata_q <= flag_mem[slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ssb_pkg::ST_CLEAR;
      clr_cnt_q    <= '0;
      step_q       <= 6'd0;
      mask_q       <= 16'd1;
      rd_pending_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ssb_pkg::ST_CLEAR) clr_cnt_q <= clr_cnt_q + RowW'(1);
      if (issue && state_q == ssb_pkg::ST_DRAW) step_q <= step_q + 6'd1;
      if (cfg_we_i) mask_q <= cfg_wdata_i;
      if (issue) begin
        rd_pending_q <= 1'b1;
      end else if (consume) begin
        rd_pending_q <= 1'b0;
      end
      if (consume) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= kind_i;
      position_q <= position_i;
      char_q     <= text_char_i;
      pos_x_q    <= pos_x_i;
      pos_y_q    <= pos_y_i;
      flip_h_q   <= flip_h_i;
      flip_v_q   <= flip_v_i;
      fidx_q     <= flag_index_i;
    end
    // keep what the result needs, the item registers may be reloaded meanwhile
    if (issue) begin
      rq_check_q <= state_q == ssb_pkg::ST_CHECK;
      rq_last_q  <= (state_q == ssb_pkg::ST_CHECK) || (step_q == 6'd63);
      rq_rx_q    <= rx;
      rq_fidx_q  <= fidx_q;
      if (state_q == ssb_pkg::ST_CHECK) begin
        rq_x_q <= 16'd0;
        rq_y_q <= 16'd0;
      end else begin
        rq_x_q <= {1'b0, pos_x_q} + {13'd0, sx};
        rq_y_q <= {1'b0, pos_y_q} + {13'd0, sy};
      end
    end
    if (consume) begin
      pixel_x_q <= rq_x_q;
      pixel_y_q <= rq_y_q;
      last_q    <= rq_last_q;
      if (rq_check_q) begin
        color_q <= 4'd0;
        we_q    <= 1'b0;
        flag_q  <= flag_rdata_q[rq_fidx_q];
      end else begin
        color_q <= pix_color;
        we_q    <= !mask_q[pix_color];
        flag_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_x_o      = pixel_x_q;
  assign pixel_y_o      = pixel_y_q;
  assign color_o        = color_q;
  assign write_enable_o = we_q;
  assign flag_value_o   = flag_q;
  assign last_o         = last_q;

  a_rmw_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ssb_pkg::ST_RMW_RD) |-> !rd_pending_q)
    else $error("load read while a result read is outstanding");

  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ssb_pkg::ST_DRAW) |-> (step_q == 6'd0))
    else $error("draw counter not back at zero");

  a_check_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && flag_value_o) |-> (last_o && !write_enable_o && pixel_x_o == 16'd0))
    else $error("flag result carries pixel data");

  a_no_write_in_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ssb_pkg::ST_DRAW || state_q == ssb_pkg::ST_CHECK) |-> (!pix_we && !flag_we))
    else $error("store written during a read walk");

endmodule
